// File: rtl/core/fnaf_pkg.sv
// Shared constants and types for the four-neighbor average filter.
package fnaf_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int SAMPLE_W  = 16;
  localparam int AVG_W     = 24;
  localparam int ROW_W     = 16;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int LEN_W     = COL_W + 1;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int FRAC_W    = 8;
  localparam int SUM_W     = SAMPLE_W + 2;
  localparam int SCL_W     = SUM_W + FRAC_W;
  localparam int RECIP3_SH = SCL_W;
  localparam int RECIP3_W  = SCL_W - 1;
  localparam int PROD_W    = SCL_W + RECIP3_W;
  localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'(((64'd1 << RECIP3_SH) + 64'd2) / 64'd3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH = 1'b0,
    CFG_ROW_COUNT  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV2 = 2'd0,
    DIV3 = 2'd1,
    DIV4 = 2'd2
  } div_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    div_t             div;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             eof;
  } job_t;

  typedef struct packed {
    logic                en;
    logic [COL_W-1:0]    col;
    logic [SAMPLE_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] prev_c;
    logic [SAMPLE_W-1:0] prev_c1;
    logic [SAMPLE_W-1:0] older_c;
  } store_rd_t;

endpackage

// File: rtl/core/fnaf_if.sv
// Input and result channel interfaces of the four-neighbor average filter.
interface fnaf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fnaf_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fnaf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fnaf_pkg::AVG_W-1:0]  average;
  logic [fnaf_pkg::ROW_W-1:0]         out_row;
  logic [fnaf_pkg::COL_W-1:0]         out_col;
  logic                               last_of_run;
  logic                               end_of_frame;

  modport source (output valid, output average, output out_row, output out_col,
                  output last_of_run, output end_of_frame, input ready);
  modport sink   (input valid, input average, input out_row, input out_col,
                  input last_of_run, input end_of_frame, output ready);
endinterface

// File: rtl/core/fnaf_line_store.sv
// Two line memories (previous row, older row) with registered reads and write bypass.
module fnaf_line_store (
  input  logic                              clk,
  input  logic [fnaf_pkg::COL_W-1:0]        rd_col,
  input  fnaf_pkg::store_wr_t               wr,
  output fnaf_pkg::store_rd_t               rd
);

  logic [fnaf_pkg::SAMPLE_W-1:0] prev_mem  [fnaf_pkg::MAX_COLS];
  logic [fnaf_pkg::SAMPLE_W-1:0] older_mem [fnaf_pkg::MAX_COLS];

  logic [fnaf_pkg::COL_W-1:0]    addr_a;
  logic [fnaf_pkg::SAMPLE_W-1:0] prev_a_r;
  logic [fnaf_pkg::SAMPLE_W-1:0] prev_b_r;
  logic [fnaf_pkg::SAMPLE_W-1:0] older_b_r;
  logic                          byp_a_r;
  logic                          byp_b_r;
  logic [fnaf_pkg::SAMPLE_W-1:0] wdata_r;
  logic [fnaf_pkg::SAMPLE_W-1:0] owdata_r;

  assign addr_a = rd_col + fnaf_pkg::COL_W'(1);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      prev_mem[wr.col]  <= wr.data;
      older_mem[wr.col] <= rd.prev_c;
    end
    prev_a_r  <= prev_mem[addr_a];
    prev_b_r  <= prev_mem[rd_col];
    older_b_r <= older_mem[rd_col];
    byp_a_r   <= wr.en && (wr.col == addr_a);
    byp_b_r   <= wr.en && (wr.col == rd_col);
    wdata_r   <= wr.data;
    owdata_r  <= rd.prev_c;
  end

  assign rd.prev_c1 = byp_a_r ? wdata_r  : prev_a_r;
  assign rd.prev_c  = byp_b_r ? wdata_r  : prev_b_r;
  assign rd.older_c = byp_b_r ? owdata_r : older_b_r;

endmodule

// File: rtl/core/four_neighbour_average_filter.sv
// Four-neighbor average filter top level: line stores, result bundle, divide pipeline.
// Each accepted word's results go to the result bundle, then stages s1, s2 and out.
// Throughput: 1 word per cycle unless the output stalls; the divide pipeline issues one
//   result per cycle, so a last-row word past column 0 (2 or 3 results) holds the input.
// Reset: counters cleared, row_length 1024, row_count 2; line memories are not cleared.
// A config write restarts the frame at row 0, column 0.
module four_neighbour_average_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fnaf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fnaf_pkg::CFG_W-1:0]         cfg_data,
  fnaf_in_if.sink                            in_chan,
  fnaf_out_if.source                         out_chan
);

  localparam int SUM_W = fnaf_pkg::SUM_W;
  localparam int COL_W = fnaf_pkg::COL_W;
  localparam int ROW_W = fnaf_pkg::ROW_W;
  localparam int LEN_W = fnaf_pkg::LEN_W;
  localparam int AVG_W = fnaf_pkg::AVG_W;
  localparam int SCL_W = fnaf_pkg::SCL_W;

  // position and frame geometry
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] last_col_r, last_col_nxt;
  logic [ROW_W-1:0] last_row_r, last_row_nxt;
  logic [LEN_W-1:0] len_w;

  logic [fnaf_pkg::SAMPLE_W-1:0] left1_r, left2_r, upm1_r;

  logic in_acc;
  fnaf_pkg::store_wr_t st_wr;
  fnaf_pkg::store_rd_t st_rd;

  // result bundle
  fnaf_pkg::job_t bnd_r [3];
  fnaf_pkg::job_t job [3];
  logic [2:0]     bnd_v_r, bnd_v_nxt, job_v, clr;
  logic [1:0]     isel;
  logic           ilast;
  logic [1:0]     cnt0;

  logic signed [SUM_W-1:0] s_e, older_e, upm1_e, prev1_e, prev0_e, left1_e, left2_e;
  logic first_col, not_last_col, last_row, row_ge1, row_ge2, col_ge2;

  // divide pipeline
  logic             s1_en, s2_en, o_en;
  logic             s1_v_r, s2_v_r, out_v_r;
  logic [SCL_W-1:0] s1_x_r;
  logic             s1_neg_r, s2_neg_r;
  fnaf_pkg::div_t   s1_div_r;
  logic [ROW_W-1:0] s1_row_r, s2_row_r, out_row_r;
  logic [COL_W-1:0] s1_col_r, s2_col_r, out_col_r;
  logic             s1_last_r, s2_last_r, out_last_r;
  logic             s1_eof_r, s2_eof_r, out_eof_r;
  logic [AVG_W-1:0] s2_q_r, q_nxt, out_avg_r;
  logic [SUM_W-1:0] isum, imag;
  logic [fnaf_pkg::PROD_W-1:0] prod;

  assign in_acc = in_chan.valid && in_chan.ready;

  // geometry and counters
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    last_col_nxt = last_col_r;
    last_row_nxt = last_row_r;
    len_w        = cfg_data[LEN_W-1:0];
    if (cfg_we) begin
      if (cfg_index == fnaf_pkg::CFG_ROW_LENGTH) begin
        if (len_w < LEN_W'(2)) begin
          last_col_nxt = COL_W'(1);
        end else if (len_w > LEN_W'(fnaf_pkg::MAX_COLS)) begin
          last_col_nxt = COL_W'(fnaf_pkg::MAX_COLS - 1);
        end else begin
          last_col_nxt = COL_W'(len_w - LEN_W'(1));
        end
      end else begin
        if (cfg_data < fnaf_pkg::CFG_W'(2)) begin
          last_row_nxt = ROW_W'(1);
        end else begin
          last_row_nxt = ROW_W'(cfg_data - fnaf_pkg::CFG_W'(1));
        end
      end
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_r == last_col_r) begin
        col_nxt = '0;
        row_nxt = (row_r == last_row_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      last_col_r <= COL_W'(fnaf_pkg::MAX_COLS - 1);
      last_row_r <= ROW_W'(1);
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      last_col_r <= last_col_nxt;
      last_row_r <= last_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      left1_r <= in_chan.sample;
      left2_r <= left1_r;
      upm1_r  <= st_rd.prev_c;
    end
  end

  assign st_wr.en   = in_acc;
  assign st_wr.col  = col_r;
  assign st_wr.data = in_chan.sample;

  fnaf_line_store u_store (
    .clk    (clk),
    .rd_col (col_nxt),
    .wr     (st_wr),
    .rd     (st_rd)
  );

  // results caused by the current word
  assign s_e     = SUM_W'(in_chan.sample);
  assign older_e = SUM_W'($signed(st_rd.older_c));
  assign upm1_e  = SUM_W'($signed(upm1_r));
  assign prev1_e = SUM_W'($signed(st_rd.prev_c1));
  assign prev0_e = SUM_W'($signed(st_rd.prev_c));
  assign left1_e = SUM_W'($signed(left1_r));
  assign left2_e = SUM_W'($signed(left2_r));

  assign first_col    = (col_r == '0);
  assign not_last_col = (col_r != last_col_r);
  assign last_row     = (row_r == last_row_r);
  assign row_ge1      = (row_r != '0);
  assign row_ge2      = (row_r > ROW_W'(1));
  assign col_ge2      = (col_r > COL_W'(1));

  assign cnt0 = 2'(row_ge2) + 2'(!first_col) + 2'(not_last_col);

  always_comb begin
    job[0].sum = s_e + (row_ge2 ? older_e : '0) + (!first_col ? upm1_e : '0)
               + (not_last_col ? prev1_e : '0);
    unique case (cnt0)
      2'd1:    job[0].div = fnaf_pkg::DIV2;
      2'd2:    job[0].div = fnaf_pkg::DIV3;
      default: job[0].div = fnaf_pkg::DIV4;
    endcase
    job[0].row = row_r - ROW_W'(1);
    job[0].col = col_r;
    job[0].eof = 1'b0;

    job[1].sum = upm1_e + s_e + (col_ge2 ? left2_e : '0);
    job[1].div = col_ge2 ? fnaf_pkg::DIV3 : fnaf_pkg::DIV2;
    job[1].row = row_r;
    job[1].col = col_r - COL_W'(1);
    job[1].eof = 1'b0;

    job[2].sum = prev0_e + left1_e;
    job[2].div = fnaf_pkg::DIV2;
    job[2].row = row_r;
    job[2].col = col_r;
    job[2].eof = 1'b1;

    job_v = {last_row && !not_last_col, last_row && !first_col, row_ge1};
  end

  // bundle issue: lowest pending slot first
  always_comb begin
    priority if (bnd_v_r[0]) begin
      isel  = 2'd0;
      ilast = ~|bnd_v_r[2:1];
    end else if (bnd_v_r[1]) begin
      isel  = 2'd1;
      ilast = ~bnd_v_r[2];
    end else begin
      isel  = 2'd2;
      ilast = 1'b1;
    end
    clr = (s1_en && (bnd_v_r != '0)) ? (3'b001 << isel) : 3'b000;
    bnd_v_nxt = in_acc ? job_v : (bnd_v_r & ~clr);
  end

  assign in_chan.ready = (bnd_v_r == '0) || (s1_en && $onehot(bnd_v_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_v_r <= '0;
    end else begin
      bnd_v_r <= bnd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bnd_r <= job;
    end
  end

  // divide pipeline: magnitude, scale, divide by 2, 3 or 4, restore sign
  assign o_en  = !out_v_r || out_chan.ready;
  assign s2_en = !s2_v_r || o_en;
  assign s1_en = !s1_v_r || s2_en;

  assign isum = bnd_r[isel].sum;
  assign imag = isum[SUM_W-1] ? (~isum + SUM_W'(1)) : isum;
  assign prod = fnaf_pkg::PROD_W'(s1_x_r) * fnaf_pkg::PROD_W'(fnaf_pkg::RECIP3);

  always_comb begin
    unique case (s1_div_r)
      fnaf_pkg::DIV2: q_nxt = s1_x_r[1 +: AVG_W];
      fnaf_pkg::DIV3: q_nxt = prod[fnaf_pkg::RECIP3_SH +: AVG_W];
      fnaf_pkg::DIV4: q_nxt = s1_x_r[2 +: AVG_W];
      default:        q_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= (bnd_v_r != '0);
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
      if (o_en) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_x_r    <= {imag, {fnaf_pkg::FRAC_W{1'b0}}};
      s1_neg_r  <= isum[SUM_W-1];
      s1_div_r  <= bnd_r[isel].div;
      s1_row_r  <= bnd_r[isel].row;
      s1_col_r  <= bnd_r[isel].col;
      s1_last_r <= ilast;
      s1_eof_r  <= bnd_r[isel].eof;
    end
    if (s2_en) begin
      s2_q_r    <= q_nxt;
      s2_neg_r  <= s1_neg_r;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_last_r <= s1_last_r;
      s2_eof_r  <= s1_eof_r;
    end
    if (o_en) begin
      out_avg_r  <= s2_neg_r ? (~s2_q_r + AVG_W'(1)) : s2_q_r;
      out_row_r  <= s2_row_r;
      out_col_r  <= s2_col_r;
      out_last_r <= s2_last_r;
      out_eof_r  <= s2_eof_r;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.average      = out_avg_r;
  assign out_chan.out_row      = out_row_r;
  assign out_chan.out_col      = out_col_r;
  assign out_chan.last_of_run  = out_last_r;
  assign out_chan.end_of_frame = out_eof_r;

  a_ready_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> ($countones(bnd_v_r) <= 1))
    else $error("input ready with more than one pending result");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= last_col_r)
    else $error("column counter past last column");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= last_row_r)
    else $error("row counter past last row");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.end_of_frame) |-> out_chan.last_of_run)
    else $error("end of frame word not last of run");

endmodule
